// File: hdl/bilinear_image_upscaler_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef BILINEAR_IMAGE_UPSCALER_DEFINES_SVH
`define BILINEAR_IMAGE_UPSCALER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BILUP_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BILUP_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bilup_pkg.sv
package bilup_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;

  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;
  localparam int FRAC_W  = 8;
  localparam int XW      = $clog2(SRC_WIDTH);
  localparam int YW      = $clog2(SRC_HEIGHT);
  localparam int MW      = (XW > YW) ? XW : YW;
  localparam int NUM_W   = COORD_W + MW + FRAC_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W  = $clog2(FRAME_DEPTH);
  localparam int PIX_W   = 24;

  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = CFG_W'(480);

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    CFG_OUT_WIDTH  = 1'b0,
    CFG_OUT_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XSTART,
    ST_XWAIT,
    ST_YSTART,
    ST_YWAIT,
    ST_MAP,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_HORZ,
    ST_VERT
  } state_t;

  typedef struct packed {
    mode_t        mode;
    logic [8:0]   src_col;
    logic [7:0]   src_row;
    logic [7:0]   in_red;
    logic [7:0]   in_green;
    logic [7:0]   in_blue;
    logic [11:0]  out_col;
    logic [11:0]  out_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] f);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, a}) + $signed(prod[17:8]);
    return sum[7:0];
  endfunction

endpackage

// File: hdl/bilup_div.sv
`include "bilinear_image_upscaler_defines.svh"

module bilup_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bilup_pkg::NUM_W-1:0]     dividend,
  input  logic [bilup_pkg::CFG_W-1:0]     divisor,
  output logic                            done,
  output logic [bilup_pkg::NUM_W-1:0]     quotient
);
  import bilup_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     quo_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     div_r;

  logic [CFG_W:0]       trial;
  logic                 take;
  logic [CFG_W-1:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    take    = (trial >= {1'b0, div_r});
    rem_nxt = take ? CFG_W'(trial - {1'b0, div_r}) : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], take};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `BILUP_AST_IMP(a_done_idle, done_r, !busy_r, "divider done while busy")
  `BILUP_AST_NXT(a_last_step, busy_r && !start && cnt_r == '0, done_r, "divider missed done")
  `BILUP_AST_IMP(a_rem_bound, busy_r, rem_r < div_r, "divider remainder out of range")

endmodule

// File: hdl/bilinear_image_upscaler.sv
// Channel | Dir | Handshake             | Beat
// in      | in  | in_valid / in_ready   | bilup_pkg::in_item_t: write pixel or read request
// out     | out | out_valid / out_ready | bilup_pkg::out_item_t: one RGB pixel per read
// cfg     | in  | cfg_valid / cfg_ready | cfg_index selects out_width or out_height
// A write beat stores the pixel at acceptance.
// A read beat runs two radix-2 divisions on the shared divider, then mapping, four reads of
// the single frame port and the blend; its pixel then loads into the output register and
// the input reopens in the cycle after the load.
// rst_n is synchronous; the frame store is not cleared and holds garbage until written.
// A finished pixel waits in the output register and a new beat is accepted meanwhile;
// a read that finishes while that register is still full holds with the input closed.
`include "bilinear_image_upscaler_defines.svh"

module bilinear_image_upscaler (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bilup_pkg::in_item_t     in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bilup_pkg::out_item_t    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  bilup_pkg::cfg_reg_t     cfg_index,
  input  logic [bilup_pkg::CFG_W-1:0] cfg_data
);
  import bilup_pkg::*;

  localparam logic [NUM_W-FRAC_W-1:0] XI_LIM = (NUM_W-FRAC_W)'(SRC_WIDTH - 2);
  localparam logic [NUM_W-FRAC_W-1:0] YI_LIM = (NUM_W-FRAC_W)'(SRC_HEIGHT - 2);
  localparam logic [XW-1:0] XI_MAX = XW'(SRC_WIDTH - 2);
  localparam logic [YW-1:0] YI_MAX = YW'(SRC_HEIGHT - 2);

  logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   width_r, height_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [NUM_W-1:0]   qx_r, qy_r;
  logic [XW-1:0]      xi_r;
  logic [YW-1:0]      yi_r;
  logic [7:0]         fx_r, fy_r;
  logic [ADDR_W-1:0]  base_r;
  logic [PIX_W-1:0]   rd_data_r, p00_r, p01_r, p10_r;
  logic [2:0][7:0]    t0_r, t1_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic                  in_acc;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_dividend, div_quotient;
  logic [CFG_W-1:0]      div_divisor;
  logic [NUM_W-FRAC_W-1:0] num_x, num_y, ix, iy;
  logic [2:0][7:0]       h0, h1, vv;
  logic                  out_load;

  // control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.mode == MODE_READ) begin
          state_nxt = ST_XSTART;
        end
      end
      ST_XSTART: begin
        div_start = 1'b1;
        state_nxt = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (div_done) begin
          state_nxt = ST_YSTART;
        end
      end
      ST_YSTART: begin
        div_start = 1'b1;
        state_nxt = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (div_done) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_HORZ;
      ST_HORZ: state_nxt = ST_VERT;
      ST_VERT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= OUT_WIDTH_RST;
      height_r <= OUT_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUT_WIDTH:  width_r  <= cfg_data;
        CFG_OUT_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame store
  assign in_acc  = in_valid && in_ready;
  assign wr_en   = in_acc && in_data.mode == MODE_WRITE &&
                   32'(in_data.src_col) < SRC_WIDTH && 32'(in_data.src_row) < SRC_HEIGHT;
  assign wr_addr = ADDR_W'(32'(in_data.src_row) * SRC_WIDTH + 32'(in_data.src_col));

  always_comb begin
    unique case (state_r)
      ST_RD1:  rd_addr = base_r + ADDR_W'(1);
      ST_RD2:  rd_addr = base_r + ADDR_W'(SRC_WIDTH);
      ST_RD3:  rd_addr = base_r + ADDR_W'(SRC_WIDTH + 1);
      default: rd_addr = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    end
    rd_data_r <= frame_mem[rd_addr];
  end

  // coordinate mapping
  assign num_x = (NUM_W-FRAC_W)'(32'(col_r) * (SRC_WIDTH - 1));
  assign num_y = (NUM_W-FRAC_W)'(32'(row_r) * (SRC_HEIGHT - 1));

  always_comb begin
    if (state_r == ST_YSTART) begin
      div_dividend = {num_y, 8'h00};
      div_divisor  = (height_r > CFG_W'(1)) ? height_r - CFG_W'(1) : CFG_W'(1);
    end else begin
      div_dividend = {num_x, 8'h00};
      div_divisor  = (width_r > CFG_W'(1)) ? width_r - CFG_W'(1) : CFG_W'(1);
    end
  end

  bilup_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign ix = qx_r[NUM_W-1:FRAC_W];
  assign iy = qy_r[NUM_W-1:FRAC_W];

  // interpolation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h0[k] = lerp8(p00_r[8*k +: 8], p01_r[8*k +: 8], fx_r);
      h1[k] = lerp8(p10_r[8*k +: 8], rd_data_r[8*k +: 8], fx_r);
      vv[k] = lerp8(t0_r[k], t1_r[k], fy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r <= in_data.out_col;
      row_r <= in_data.out_row;
    end
    if (state_r == ST_XWAIT && div_done) begin
      qx_r <= div_quotient;
    end
    if (state_r == ST_YWAIT && div_done) begin
      qy_r <= div_quotient;
    end
    if (state_r == ST_MAP) begin
      if (ix > XI_LIM) begin
        xi_r <= XI_MAX;
        fx_r <= '0;
      end else begin
        xi_r <= ix[XW-1:0];
        fx_r <= qx_r[FRAC_W-1:0];
      end
      if (iy > YI_LIM) begin
        yi_r <= YI_MAX;
        fy_r <= '0;
      end else begin
        yi_r <= iy[YW-1:0];
        fy_r <= qy_r[FRAC_W-1:0];
      end
    end
    if (state_r == ST_ADDR) begin
      base_r <= ADDR_W'(32'(yi_r) * SRC_WIDTH + 32'(xi_r));
    end
    if (state_r == ST_RD1) begin
      p00_r <= rd_data_r;
    end
    if (state_r == ST_RD2) begin
      p01_r <= rd_data_r;
    end
    if (state_r == ST_RD3) begin
      p10_r <= rd_data_r;
    end
    if (state_r == ST_HORZ) begin
      t0_r <= h0;
      t1_r <= h1;
    end
    if (out_load) begin
      out_data_r.red   <= vv[2];
      out_data_r.green <= vv[1];
      out_data_r.blue  <= vv[0];
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BILUP_AST_NXT(a_read_starts, in_acc && in_data.mode == MODE_READ, state_r == ST_XSTART, "read beat did not start mapping")
  `BILUP_AST_IMP(a_div_owner, div_done, state_r == ST_XWAIT || state_r == ST_YWAIT, "divider result with no taker")
  `BILUP_AST_IMP(a_idx_clamped, state_r == ST_ADDR, xi_r <= XI_MAX && yi_r <= YI_MAX, "source index beyond clamp")

endmodule
